@@ hw/rtl/sms_pkg.sv @@
// Shared types and constants for the sprite motion step block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sms_pkg;

    // Fraction bits of the signed 16.8 position format.
    localparam int SMS_FRAC = 8;
    // Width of |velocity| * elapsed_ms (16 x 10 bits).
    localparam int SMS_MAG_W = 26;
    // Quotient width of the motion divide, one pipeline stage per bit.
    localparam int SMS_QW = SMS_MAG_W + SMS_FRAC;
    // Width of the update interval divisor.
    localparam int SMS_DVW = 10;
    // Width of the frame modulo lane (frame_index + 1 and the number of frames).
    localparam int SMS_FW = 9;
    // Register width of the configuration write data.
    localparam int SMS_CFG_W = 12;
    // Stages from input to output: input stage, divider, three finishing stages.
    localparam int SMS_DEPTH = SMS_QW + 4;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SCREEN_WIDTH    = 3'd0,
        CFG_SCREEN_HEIGHT   = 3'd1,
        CFG_SPRITE_WIDTH    = 3'd2,
        CFG_SPRITE_HEIGHT   = 3'd3,
        CFG_UPDATE_INTERVAL = 3'd4,
        CFG_ANIM_FRAMES     = 3'd5,
        CFG_MOVE_ENABLE     = 3'd6
    } cfg_index_t;

    // One sprite record as it arrives.
    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic        [7:0]  frame_index;
        logic        [15:0] anim_timer;
        logic        [15:0] anim_dur;
        logic        [9:0]  elapsed_ms;
    } sms_in_t;

    // One updated sprite record.
    typedef struct packed {
        logic signed [23:0] new_pos_x;
        logic signed [23:0] new_pos_y;
        logic signed [15:0] new_vel_x;
        logic signed [15:0] new_vel_y;
        logic        [7:0]  new_frame_index;
        logic        [15:0] new_anim_timer;
    } sms_out_t;

    // Dividend lanes entering the divider pipeline.
    typedef struct packed {
        logic [SMS_MAG_W-1:0] mag_x;
        logic [SMS_MAG_W-1:0] mag_y;
        logic [SMS_FW-1:0]    frame_num;
    } sms_div_in_t;

    // Quotients and remainder leaving the divider pipeline.
    typedef struct packed {
        logic [SMS_QW-1:0] q_x;
        logic [SMS_QW-1:0] q_y;
        logic [SMS_FW-1:0] frame_mod;
    } sms_div_out_t;

endpackage

`default_nettype wire

@@ hw/rtl/sms_divpipe.sv @@
// Pipelined restoring divider: one quotient bit per stage for both motion
// axes, and a frame modulo lane in the first stages. Depends on sms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sms_divpipe
    import sms_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [SMS_DVW-1:0] divisor,
    input  wire logic [SMS_FW-1:0]  frame_divisor,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sms_div_in_t        in_data,
    input  wire sms_in_t            in_side,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sms_div_out_t            out_data,
    output sms_in_t                 out_side
);

    localparam int N = SMS_QW;

    // Per-stage registers; the low part of each work word collects quotient bits.
    logic                v_reg    [N];
    logic                rdy      [N+1];
    logic [SMS_QW-1:0]   wx_reg   [N];
    logic [SMS_QW-1:0]   wy_reg   [N];
    logic [SMS_DVW-1:0]  rx_reg   [N];
    logic [SMS_DVW-1:0]  ry_reg   [N];
    logic [SMS_FW-1:0]   wf_reg   [N];
    logic [SMS_FW-1:0]   rf_reg   [N];
    sms_in_t             side_reg [N];

    assign rdy[N]   = out_ready;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                v_in;
        logic [SMS_QW-1:0]   wx_in, wy_in, wx_nx, wy_nx;
        logic [SMS_DVW-1:0]  rx_in, ry_in, rx_nx, ry_nx;
        logic [SMS_DVW:0]    tx, ty;
        logic [SMS_FW-1:0]   wf_in, rf_in, wf_nx, rf_nx;
        logic [SMS_FW:0]     tf;
        sms_in_t             side_in;

        // Stage input: the entering beat or the previous stage.
        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign wx_in   = {in_data.mag_x, {SMS_FRAC{1'b0}}};
            assign wy_in   = {in_data.mag_y, {SMS_FRAC{1'b0}}};
            assign rx_in   = '0;
            assign ry_in   = '0;
            assign wf_in   = in_data.frame_num;
            assign rf_in   = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign wx_in   = wx_reg[k-1];
            assign wy_in   = wy_reg[k-1];
            assign rx_in   = rx_reg[k-1];
            assign ry_in   = ry_reg[k-1];
            assign wf_in   = wf_reg[k-1];
            assign rf_in   = rf_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // One restoring step per axis: shift in a dividend bit, trial subtract.
        always_comb begin
            tx = {rx_in, wx_in[SMS_QW-1]};
            ty = {ry_in, wy_in[SMS_QW-1]};
            if (tx >= {1'b0, divisor}) begin
                rx_nx = SMS_DVW'(tx - {1'b0, divisor});
                wx_nx = {wx_in[SMS_QW-2:0], 1'b1};
            end else begin
                rx_nx = tx[SMS_DVW-1:0];
                wx_nx = {wx_in[SMS_QW-2:0], 1'b0};
            end
            if (ty >= {1'b0, divisor}) begin
                ry_nx = SMS_DVW'(ty - {1'b0, divisor});
                wy_nx = {wy_in[SMS_QW-2:0], 1'b1};
            end else begin
                ry_nx = ty[SMS_DVW-1:0];
                wy_nx = {wy_in[SMS_QW-2:0], 1'b0};
            end
        end

        // The frame lane needs only as many steps as its width; later stages carry it.
        always_comb begin
            tf = {rf_in, wf_in[SMS_FW-1]};
            if (k < SMS_FW) begin
                if (tf >= {1'b0, frame_divisor}) begin
                    rf_nx = SMS_FW'(tf - {1'b0, frame_divisor});
                    wf_nx = {wf_in[SMS_FW-2:0], 1'b1};
                end else begin
                    rf_nx = tf[SMS_FW-1:0];
                    wf_nx = {wf_in[SMS_FW-2:0], 1'b0};
                end
            end else begin
                rf_nx = rf_in;
                wf_nx = wf_in;
            end
        end

        // A stage moves when it is empty or its successor moves.
        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && v_in) begin
                wx_reg[k]   <= wx_nx;
                wy_reg[k]   <= wy_nx;
                rx_reg[k]   <= rx_nx;
                ry_reg[k]   <= ry_nx;
                wf_reg[k]   <= wf_nx;
                rf_reg[k]   <= rf_nx;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid          = v_reg[N-1];
    assign out_data.q_x       = wx_reg[N-1];
    assign out_data.q_y       = wy_reg[N-1];
    assign out_data.frame_mod = rf_reg[N-1];
    assign out_side           = side_reg[N-1];

endmodule

`default_nettype wire

@@ hw/rtl/sprite_motion_step.sv @@
// Top level of the sprite motion step: configuration registers, input stage
// with multiply, divider pipeline and finishing stages. Depends on sms_pkg, sms_divpipe.
//
//   Channel  Ports                                 Beat
//   input    s_valid, s_ready, s_data (sms_in_t)   one sprite record
//   result   m_valid, m_ready, m_data (sms_out_t)  one updated record
//   config   cfg_valid, cfg_ready, cfg_index,      one register write
//            cfg_data
//
// A record passes 38 register stages: one multiply stage, 34 divider stages
// (one quotient bit each) and three finishing stages. A new record can enter
// every cycle unless a stall on the result side has backed up to the input stage.
// Reset is synchronous and active low; it empties the pipeline and loads
// the register defaults. A stall on the result side backs up stage by stage,
// so empty stages keep filling while the output beat waits.
`timescale 1ns / 1ps
`default_nettype none

module sprite_motion_step
    import sms_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire sms_in_t              s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output sms_out_t                  m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [SMS_CFG_W-1:0] cfg_data
);

    localparam int STEP_W = SMS_QW - SMS_FRAC + 2;
    localparam int SUM_W  = STEP_W + 1;

    typedef struct packed {
        logic signed [23:0]       pos_x;
        logic signed [23:0]       pos_y;
        logic signed [15:0]       vel_x;
        logic signed [15:0]       vel_y;
        logic signed [STEP_W-1:0] step_x;
        logic signed [STEP_W-1:0] step_y;
        logic                     upd;
        logic        [7:0]        frame;
        logic        [15:0]       timer;
    } f1_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [15:0]      vel_x;
        logic signed [15:0]      vel_y;
        logic                    mv;
        logic        [7:0]       frame;
        logic        [15:0]      timer;
    } f2_t;

    typedef struct packed {
        logic signed [23:0] pos;
        logic signed [15:0] vel;
    } axis_t;

    // Negation that saturates the most negative velocity.
    function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
        return (v == 16'sh8000) ? 16'sh7FFF : -v;
    endfunction

    // Clamp one axis to its bounds and reflect an outward velocity.
    function automatic axis_t clamp_axis(input logic signed [SUM_W-1:0] sum,
                                         input logic signed [15:0]      vel,
                                         input logic [11:0]             screen,
                                         input logic [8:0]              size);
        logic        [7:0]       half;
        logic signed [12:0]      diff;
        logic signed [SUM_W-1:0] lo, hi, p;
        logic signed [15:0]      v;
        axis_t                   r;
        half = size[8:1];
        diff = $signed({1'b0, screen}) - $signed({5'b0, half});
        lo   = -$signed({{(SUM_W-16){1'b0}}, half, 8'b0});
        hi   = {{(SUM_W-21){diff[12]}}, diff, 8'b0};
        p    = sum;
        v    = vel;
        if (p < lo) begin
            p = lo;
            if (v < 0) begin
                v = neg_sat16(v);
            end
        end
        if (p > hi) begin
            p = hi;
            if (v > 0) begin
                v = neg_sat16(v);
            end
        end
        r.pos = p[23:0];
        r.vel = v;
        return r;
    endfunction

    // Configuration registers.
    logic [11:0]        screen_w_reg, screen_h_reg;
    logic [8:0]         sprite_w_reg, sprite_h_reg;
    logic [SMS_DVW-1:0] interval_reg;
    logic [SMS_FW-1:0]  fcount_reg;
    logic               move_en_reg;
    logic [SMS_DVW-1:0] interval_eff;
    logic [SMS_FW-1:0]  fcount_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_w_reg <= 12'd640;
            screen_h_reg <= 12'd480;
            sprite_w_reg <= 9'd32;
            sprite_h_reg <= 9'd32;
            interval_reg <= SMS_DVW'(16);
            fcount_reg   <= SMS_FW'(8);
            move_en_reg  <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:    screen_w_reg <= cfg_data[11:0];
                CFG_SCREEN_HEIGHT:   screen_h_reg <= cfg_data[11:0];
                CFG_SPRITE_WIDTH:    sprite_w_reg <= cfg_data[8:0];
                CFG_SPRITE_HEIGHT:   sprite_h_reg <= cfg_data[8:0];
                CFG_UPDATE_INTERVAL: interval_reg <= cfg_data[SMS_DVW-1:0];
                CFG_ANIM_FRAMES:     fcount_reg   <= cfg_data[SMS_FW-1:0];
                CFG_MOVE_ENABLE:     move_en_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // A zero interval or frame count behaves as one.
    assign interval_eff = (interval_reg == '0) ? SMS_DVW'(1) : interval_reg;
    assign fcount_eff   = (fcount_reg == '0) ? SMS_FW'(1) : fcount_reg;

    // Input stage: velocity magnitude times elapsed time.
    logic              s0_v_reg;
    sms_in_t           s0_side_reg;
    sms_div_in_t       s0_div_reg;
    logic              s0_rdy;
    logic [15:0]       abs_x, abs_y;
    logic              d_in_ready;

    assign abs_x  = s_data.vel_x[15] ? (~s_data.vel_x + 16'd1) : s_data.vel_x;
    assign abs_y  = s_data.vel_y[15] ? (~s_data.vel_y + 16'd1) : s_data.vel_y;
    assign s0_rdy = !s0_v_reg || d_in_ready;
    assign s_ready = s0_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_v_reg <= 1'b0;
        end else if (s0_rdy) begin
            s0_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s0_rdy && s_valid) begin
            s0_side_reg          <= s_data;
            s0_div_reg.mag_x     <= SMS_MAG_W'(abs_x) * SMS_MAG_W'(s_data.elapsed_ms);
            s0_div_reg.mag_y     <= SMS_MAG_W'(abs_y) * SMS_MAG_W'(s_data.elapsed_ms);
            s0_div_reg.frame_num <= {1'b0, s_data.frame_index} + SMS_FW'(1);
        end
    end

    // Divider pipeline.
    logic         d_v, d_rdy;
    sms_div_out_t d_out;
    sms_in_t      d_side;

    sms_divpipe u_div (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .divisor       (interval_eff),
        .frame_divisor (fcount_eff),
        .in_valid      (s0_v_reg),
        .in_ready      (d_in_ready),
        .in_data       (s0_div_reg),
        .in_side       (s0_side_reg),
        .out_valid     (d_v),
        .out_ready     (d_rdy),
        .out_data      (d_out),
        .out_side      (d_side)
    );

    // Finishing stage 1: floor to whole steps, timer and frame update.
    logic              f1_v_reg, f2_v_reg, f3_v_reg;
    logic              f1_rdy, f2_rdy, f3_rdy;
    f1_t               f1_reg, f1_next;
    f2_t               f2_reg, f2_next;
    sms_out_t          out_reg, out_next;
    logic [SMS_QW:0]   qpx, qpy;
    logic [16:0]       t_sum, t_sub;
    logic              t_hit;
    axis_t             ax, ay;

    assign f3_rdy = !f3_v_reg || m_ready;
    assign f2_rdy = !f2_v_reg || f3_rdy;
    assign f1_rdy = !f1_v_reg || f2_rdy;
    assign d_rdy  = f1_rdy;

    always_comb begin
        qpx = {1'b0, d_out.q_x} + (SMS_QW+1)'(255);
        qpy = {1'b0, d_out.q_y} + (SMS_QW+1)'(255);
        f1_next.pos_x  = d_side.pos_x;
        f1_next.pos_y  = d_side.pos_y;
        f1_next.vel_x  = d_side.vel_x;
        f1_next.vel_y  = d_side.vel_y;
        f1_next.step_x = d_side.vel_x[15] ? -$signed({1'b0, qpx[SMS_QW:SMS_FRAC]})
                                          : $signed({2'b0, d_out.q_x[SMS_QW-1:SMS_FRAC]});
        f1_next.step_y = d_side.vel_y[15] ? -$signed({1'b0, qpy[SMS_QW:SMS_FRAC]})
                                          : $signed({2'b0, d_out.q_y[SMS_QW-1:SMS_FRAC]});
        f1_next.upd    = d_side.elapsed_ms >= interval_eff;
        t_sum = {1'b0, d_side.anim_timer} + {7'b0, d_side.elapsed_ms};
        t_hit = t_sum >= {1'b0, d_side.anim_dur};
        t_sub = t_hit ? (t_sum - {1'b0, d_side.anim_dur}) : t_sum;
        if (f1_next.upd) begin
            f1_next.timer = t_sub[16] ? 16'hFFFF : t_sub[15:0];
            f1_next.frame = t_hit ? d_out.frame_mod[7:0] : d_side.frame_index;
        end else begin
            f1_next.timer = d_side.anim_timer;
            f1_next.frame = d_side.frame_index;
        end
    end

    // Finishing stage 2: add the step to the position when movement is enabled and due.
    always_comb begin
        f2_next.sum_x = {{(SUM_W-24){f1_reg.pos_x[23]}}, f1_reg.pos_x}
                      + {f1_reg.step_x[STEP_W-1], f1_reg.step_x};
        f2_next.sum_y = {{(SUM_W-24){f1_reg.pos_y[23]}}, f1_reg.pos_y}
                      + {f1_reg.step_y[STEP_W-1], f1_reg.step_y};
        f2_next.vel_x = f1_reg.vel_x;
        f2_next.vel_y = f1_reg.vel_y;
        f2_next.mv    = f1_reg.upd && move_en_reg;
        f2_next.frame = f1_reg.frame;
        f2_next.timer = f1_reg.timer;
        if (!f2_next.mv) begin
            f2_next.sum_x = {{(SUM_W-24){f1_reg.pos_x[23]}}, f1_reg.pos_x};
            f2_next.sum_y = {{(SUM_W-24){f1_reg.pos_y[23]}}, f1_reg.pos_y};
        end
    end

    // Finishing stage 3: clamp to the screen bounds when the sprite moved.
    always_comb begin
        ax = clamp_axis(f2_reg.sum_x, f2_reg.vel_x, screen_w_reg, sprite_w_reg);
        ay = clamp_axis(f2_reg.sum_y, f2_reg.vel_y, screen_h_reg, sprite_h_reg);
        if (f2_reg.mv) begin
            out_next.new_pos_x = ax.pos;
            out_next.new_pos_y = ay.pos;
            out_next.new_vel_x = ax.vel;
            out_next.new_vel_y = ay.vel;
        end else begin
            out_next.new_pos_x = f2_reg.sum_x[23:0];
            out_next.new_pos_y = f2_reg.sum_y[23:0];
            out_next.new_vel_x = f2_reg.vel_x;
            out_next.new_vel_y = f2_reg.vel_y;
        end
        out_next.new_frame_index = f2_reg.frame;
        out_next.new_anim_timer  = f2_reg.timer;
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end else begin
            if (f1_rdy) begin
                f1_v_reg <= d_v;
            end
            if (f2_rdy) begin
                f2_v_reg <= f1_v_reg;
            end
            if (f3_rdy) begin
                f3_v_reg <= f2_v_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (f1_rdy && d_v) begin
            f1_reg <= f1_next;
        end
        if (f2_rdy && f1_v_reg) begin
            f2_reg <= f2_next;
        end
        if (f3_rdy && f2_v_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = f3_v_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sms_checker.sv @@
// Port-level checker for the sprite motion step, bound to the top level.
// Depends on sms_pkg and sprite_motion_step.
`timescale 1ns / 1ps
`default_nettype none

module sms_checker
    import sms_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire sms_out_t m_data
);

    localparam int CW = $clog2(SMS_DEPTH + 1);

    // Records accepted but not yet delivered.
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb begin
        cnt_next = cnt_reg;
        if (s_valid && s_ready) begin
            cnt_next = cnt_next + CW'(1);
        end
        if (m_valid && m_ready) begin
            cnt_next = cnt_next - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // A waiting result beat holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // No result appears without a record in flight.
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> cnt_reg != '0)
        else $error("result beat without an accepted record");

    // The pipeline never holds more records than it has stages.
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(SMS_DEPTH))
        else $error("more records in flight than pipeline stages");

endmodule

bind sprite_motion_step sms_checker u_sms_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

@@ sim/sprite_record_checker.sv @@
// Checker for the sprite motion step: predicts each updated record and compares results.
// Depends on sms_pkg; instantiated beside the block by tb_sprite_motion_step.
`timescale 1ns / 1ps

module sprite_record_checker
    import sms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  sms_in_t              s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  sms_out_t             m_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [SMS_CFG_W-1:0] cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   checked
);

    typedef struct packed {
        longint p;
        longint v;
    } axis_t;

    // Shadow copy of the configuration registers.
    logic [11:0] scr_w;
    logic [11:0] scr_h;
    logic [8:0]  spr_w;
    logic [8:0]  spr_h;
    logic [9:0]  upd_iv;
    logic [8:0]  frame_cnt;
    logic        move_en;

    sms_out_t expected_records[$];
    sms_out_t want;

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    // Negation that saturates at the largest positive velocity.
    function automatic longint reflect_vel(input longint v);
        longint r;
        r = -v;
        return (r > 32767) ? 32767 : r;
    endfunction

    // Moves one coordinate by its scaled velocity and applies the screen bounds.
    function automatic axis_t step_axis(input longint p, input longint v, input longint el,
                                        input longint iv, input longint scr,
                                        input longint size);
        longint q;
        longint lo;
        longint hi;
        axis_t  a;
        q   = (v * el * 256) / iv;
        lo  = -(size / 2) * 256;
        hi  = (scr - size / 2) * 256;
        // An arithmetic shift gives the floor for negative steps.
        a.p = p + (q >>> 8);
        a.v = v;
        if (a.p < lo) begin
            a.p = lo;
            if (a.v < 0) a.v = reflect_vel(a.v);
        end
        if (a.p > hi) begin
            a.p = hi;
            if (a.v > 0) a.v = reflect_vel(a.v);
        end
        return a;
    endfunction

    // Works out the updated record under the current register settings.
    function automatic sms_out_t predict_record(input sms_in_t r);
        longint   px;
        longint   py;
        longint   vx;
        longint   vy;
        longint   iv;
        longint   el;
        longint   fc;
        longint   fr;
        longint   timer;
        longint   dur;
        axis_t    ax;
        sms_out_t o;
        px    = longint'(r.pos_x);
        py    = longint'(r.pos_y);
        vx    = longint'(r.vel_x);
        vy    = longint'(r.vel_y);
        fr    = longint'(r.frame_index);
        timer = longint'(r.anim_timer);
        dur   = longint'(r.anim_dur);
        el    = longint'(r.elapsed_ms);
        iv    = (upd_iv == 10'd0) ? 64'sd1 : longint'(upd_iv);
        if (el >= iv) begin
            fc = (frame_cnt == 9'd0) ? 64'sd1 : longint'(frame_cnt);
            if (move_en) begin
                ax = step_axis(px, vx, el, iv, longint'(scr_w), longint'(spr_w));
                px = ax.p;
                vx = ax.v;
                ax = step_axis(py, vy, el, iv, longint'(scr_h), longint'(spr_h));
                py = ax.p;
                vy = ax.v;
            end
            timer = timer + el;
            if (timer >= dur) begin
                fr    = ((fr + 1) % fc) & 255;
                timer = timer - dur;
            end
            if (timer > 65535) timer = 65535;
        end
        o.new_pos_x       = px[23:0];
        o.new_pos_y       = py[23:0];
        o.new_vel_x       = vx[15:0];
        o.new_vel_y       = vy[15:0];
        o.new_frame_index = fr[7:0];
        o.new_anim_timer  = timer[15:0];
        return o;
    endfunction

    task automatic check_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // Watch all three channels; results are checked before new records are queued.
    always @(posedge aclk) begin
        if (!aresetn) begin
            scr_w     = 12'd640;
            scr_h     = 12'd480;
            spr_w     = 9'd32;
            spr_h     = 9'd32;
            upd_iv    = 10'd16;
            frame_cnt = 9'd8;
            move_en   = 1'b1;
            expected_records.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_records.size() == 0) begin
                    $error("result beat with no record outstanding");
                    fail_count++;
                end else begin
                    want = expected_records.pop_front();
                    check_field("new_pos_x", longint'(want.new_pos_x),
                                longint'(m_data.new_pos_x));
                    check_field("new_pos_y", longint'(want.new_pos_y),
                                longint'(m_data.new_pos_y));
                    check_field("new_vel_x", longint'(want.new_vel_x),
                                longint'(m_data.new_vel_x));
                    check_field("new_vel_y", longint'(want.new_vel_y),
                                longint'(m_data.new_vel_y));
                    check_field("new_frame_index", longint'(want.new_frame_index),
                                longint'(m_data.new_frame_index));
                    check_field("new_anim_timer", longint'(want.new_anim_timer),
                                longint'(m_data.new_anim_timer));
                    checked++;
                end
            end
            if (s_valid && s_ready) expected_records.push_back(predict_record(s_data));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:    scr_w     = cfg_data[11:0];
                    CFG_SCREEN_HEIGHT:   scr_h     = cfg_data[11:0];
                    CFG_SPRITE_WIDTH:    spr_w     = cfg_data[8:0];
                    CFG_SPRITE_HEIGHT:   spr_h     = cfg_data[8:0];
                    CFG_UPDATE_INTERVAL: upd_iv    = cfg_data[9:0];
                    CFG_ANIM_FRAMES:     frame_cnt = cfg_data[8:0];
                    CFG_MOVE_ENABLE:     move_en   = cfg_data[0];
                    default: ;
                endcase
            end
        end
        pending = expected_records.size();
    end

endmodule

@@ sim/tb_sprite_motion_step.sv @@
// Testbench top for sprite_motion_step: clock, reset, record and register stimulus.
// Depends on sms_pkg, sprite_motion_step and sprite_record_checker.
`timescale 1ns / 1ps

module tb_sprite_motion_step;
    import sms_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    sms_in_t              s_data;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    sms_out_t             m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [2:0]           cfg_index;
    logic [SMS_CFG_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int checked;
    int cycles = 0;
    int records_sent = 0;
    int settings_used = 1;
    bit steady = 1'b0;

    // Register values currently loaded, used to aim the random records.
    int cur_sw = 640;
    int cur_sh = 480;
    int cur_spw = 32;
    int cur_sph = 32;
    int cur_iv = 16;
    int cur_fc = 8;

    sprite_motion_step dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sprite_record_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result side: stall now and then, except during the steady stretch.
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 6);
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic sms_in_t mk(input int px, input int py, input int vx, input int vy,
                                   input int fi, input int ft, input int fd, input int el);
        sms_in_t r;
        r.pos_x       = px[23:0];
        r.pos_y       = py[23:0];
        r.vel_x       = vx[15:0];
        r.vel_y       = vy[15:0];
        r.frame_index = fi[7:0];
        r.anim_timer  = ft[15:0];
        r.anim_dur    = fd[15:0];
        r.elapsed_ms  = el[9:0];
        return r;
    endfunction

    // Mostly near the visible area so that the bounds are hit from both sides.
    function automatic int pick_pos(input int scr, input int spr);
        if ($urandom_range(3) == 0) return int'($urandom);
        return int'($urandom_range(0, (scr + spr) * 256 + 4096)) - (spr / 2) * 256 - 2048;
    endfunction

    function automatic int pick_vel();
        case ($urandom_range(9))
            0, 1: begin
                case ($urandom_range(4))
                    0: return -32768;
                    1: return 32767;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            2, 3, 4: return int'($urandom);
            default: return int'($urandom_range(0, 2047)) - 1024;
        endcase
    endfunction

    function automatic sms_in_t rand_record();
        sms_in_t r;
        int      iv_eff;
        int      fc_eff;
        iv_eff = (cur_iv == 0) ? 1 : cur_iv;
        fc_eff = (cur_fc == 0) ? 1 : ((cur_fc > 256) ? 256 : cur_fc);
        r.pos_x = 24'(pick_pos(cur_sw, cur_spw));
        r.pos_y = 24'(pick_pos(cur_sh, cur_sph));
        r.vel_x = 16'(pick_vel());
        r.vel_y = 16'(pick_vel());
        if ($urandom_range(99) < 75) r.frame_index = 8'($urandom_range(0, fc_eff - 1));
        else r.frame_index = 8'($urandom);
        if ($urandom_range(1) == 0) r.anim_timer = 16'($urandom_range(0, 3000));
        else r.anim_timer = 16'($urandom);
        case ($urandom_range(9))
            0: r.anim_dur = 16'd0;
            1: r.anim_dur = 16'd1;
            2, 3, 4, 5: r.anim_dur = 16'($urandom_range(1, 3000));
            default: r.anim_dur = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: r.elapsed_ms = 10'($urandom_range(iv_eff, 1023));
            6, 7: r.elapsed_ms = 10'($urandom_range(0, iv_eff - 1));
            default: r.elapsed_ms = 10'($urandom);
        endcase
        return r;
    endfunction

    // Sends one record beat; called and returning at a falling edge.
    task automatic push_record(input sms_in_t r);
        while (!steady && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        records_sent++;
        @(negedge aclk);
    endtask

    // One register write beat; the caller lowers cfg_valid after the last one.
    task automatic write_reg(input cfg_index_t idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[SMS_CFG_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Drains the pipeline, loads a full register setting, then streams random records.
    task automatic run_phase(input int sw, input int sh, input int spw, input int sph,
                             input int iv, input int fc, input int me, input int n);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        write_reg(CFG_SCREEN_WIDTH, sw);
        write_reg(CFG_SCREEN_HEIGHT, sh);
        write_reg(CFG_SPRITE_WIDTH, spw);
        write_reg(CFG_SPRITE_HEIGHT, sph);
        write_reg(CFG_UPDATE_INTERVAL, iv);
        write_reg(CFG_ANIM_FRAMES, fc);
        write_reg(CFG_MOVE_ENABLE, me);
        cfg_valid <= 1'b0;
        cur_sw  = sw;
        cur_sh  = sh;
        cur_spw = spw;
        cur_sph = sph;
        cur_iv  = iv;
        cur_fc  = fc;
        settings_used++;
        repeat (n) push_record(rand_record());
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SCREEN_WIDTH;
        cfg_data  = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed records under the reset settings (bounds x -4096..159744, y -4096..118784).
        push_record(mk(0, 0, 0, 0, 0, 0, 100, 0));
        push_record(mk(8388607, -8388608, 32767, -32768, 255, 65535, 65535, 15));
        push_record(mk(50000, 30000, 300, -300, 3, 10, 100, 16));
        push_record(mk(50000, 30000, -1, -1, 2, 0, 100, 17));
        push_record(mk(50000, 30000, 1, 1, 2, 0, 100, 17));
        push_record(mk(0, 0, 32767, 32767, 7, 0, 1, 1023));
        push_record(mk(-8388608, -8388608, -32768, -32768, 0, 0, 0, 16));
        push_record(mk(8388607, 8388607, 0, 0, 1, 5, 10, 20));
        push_record(mk(8388607, 8388607, -5, -5, 1, 5, 10, 20));
        push_record(mk(-8388608, 0, 5, 0, 4, 0, 500, 30));
        push_record(mk(100, 100, -32768, 32767, 255, 0, 1, 16));
        push_record(mk(1000, 1000, 10, 10, 3, 65535, 0, 1023));
        push_record(mk(1000, 1000, 10, 10, 3, 65535, 65535, 1023));
        push_record(mk(1000, 1000, 10, 10, 3, 0, 65535, 1023));
        push_record(mk(-4096, 118784, -10, 10, 6, 99, 100, 16));
        push_record(mk(159744, -4096, -32768, 32767, 5, 1000, 2000, 1023));
        repeat (120) push_record(rand_record());

        // Largest screen, 256-pixel sprite, fastest update, 256 frames.
        run_phase(4095, 4095, 256, 256, 1, 256, 1, 130);
        // Small screen, one-pixel sprite, one frame and a long interval, with movement frozen, then moving.
        run_phase(16, 16, 1, 1, 1000, 1, 0, 130);
        steady = 1'b1;
        run_phase(16, 16, 1, 1, 1000, 1, 1, 150);
        steady = 1'b0;

        // Zero interval and zero frame count are both treated as one; oversize sprite.
        run_phase(640, 480, 511, 511, 0, 0, 1, 0);
        push_record(mk(0, 0, 100, -100, 5, 0, 0, 0));
        push_record(mk(0, 0, 100, -100, 5, 0, 0, 1));
        push_record(mk(50000, 50000, -32768, 32767, 255, 65000, 1000, 1023));
        repeat (120) push_record(rand_record());

        // Frame count above the 8-bit frame range.
        run_phase(64, 48, 20, 300, 1, 300, 1, 130);

        // Random settings.
        repeat (5) begin
            run_phase($urandom_range(16, 4095), $urandom_range(16, 4095),
                      $urandom_range(1, 256), $urandom_range(1, 256),
                      ($urandom_range(1) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 1000),
                      $urandom_range(1, 256), ($urandom_range(4) != 0), 130);
        end

        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (2 * SMS_DEPTH) @(negedge aclk);

        $display("Run covered %0d records over %0d register settings; %0d results compared.",
                 records_sent, settings_used, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/sms_pkg.sv
hw/rtl/sms_divpipe.sv
hw/rtl/sprite_motion_step.sv
hw/rtl/sms_checker.sv
sim/sprite_record_checker.sv
sim/tb_sprite_motion_step.sv
